>>> rtl/timer_prescaler_top_search_defines.svh
// Assertion macros shared by the timer prescaler search RTL.
`ifndef TIMER_PRESCALER_TOP_SEARCH_DEFINES_SVH
`define TIMER_PRESCALER_TOP_SEARCH_DEFINES_SVH

// Checks that a property holds on every clock edge outside of reset.
`define TPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define TPS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

>>> rtl/tps_pkg.sv
// Package with types, constants and helper functions for the prescaler search.
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;

  localparam int unsigned TPS_LANES = 7;
  localparam logic [6:0] CLOCK_RESET = 7'd16;
  localparam logic [15:0] WIDE_MAX = 16'hFFFF;
  localparam logic [15:0] NARROW_MAX = 16'h00FF;

  typedef struct packed {
    logic        cand;
    logic [15:0] ticks;
    logic [10:0] num;
    logic [6:0]  rem;
    logic [10:0] quo;
  } tps_lane_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  code;
    logic [15:0] ticks;
    logic [10:0] err;
  } tps_pick_t;

  function automatic logic [3:0] div_shift(input logic [2:0] k);
    logic [3:0] s;
    case (k)
      3'd0: s = 4'd0;
      3'd1: s = 4'd3;
      3'd2: s = 4'd5;
      3'd3: s = 4'd6;
      3'd4: s = 4'd7;
      3'd5: s = 4'd8;
      3'd6: s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic tps_lane_t div_step(input tps_lane_t ln, input logic [6:0] c,
                                         input logic [3:0] idx);
    tps_lane_t  r;
    logic [7:0] t;
    r = ln;
    t = {ln.rem, ln.num[idx]};
    if (t >= {1'b0, c}) begin
      t = t - {1'b0, c};
      r.quo[idx] = 1'b1;
    end
    r.rem = t[6:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tps_pick.sv
// Selects the candidate divider with the smallest error, lowest code on ties.
`timescale 1ns / 1ps
`default_nettype none
module tps_pick
  import tps_pkg::*;
(
  input  tps_lane_t lanes_i [TPS_LANES],
  output tps_pick_t pick_o
);

  always_comb begin
    pick_o = '0;
    for (int k = 0; k < TPS_LANES; k++) begin
      if (lanes_i[k].cand && (!pick_o.found || lanes_i[k].quo < pick_o.err)) begin
        pick_o.found = 1'b1;
        pick_o.code  = 3'(k + 1);
        pick_o.ticks = lanes_i[k].ticks;
        pick_o.err   = lanes_i[k].quo;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/timer_prescaler_top_search.sv
// Top level of the timer prescaler and top value search pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Takes one request word per cycle and returns one result word per request at a sustained
// rate of one word per cycle while out_stall_i is low. A request passes seven register stages:
// the input multiplier stage, the candidate stage, four stages of a pipelined restoring
// divider that forms the error of each divider setting three quotient bits at a time (two in
// the last stage), and the selection and output stage. Each stage moves forward when its
// successor has room, so a stalled output only holds back the stages that are full behind it.
module timer_prescaler_top_search
  import tps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] requested_period_us_i,
  input  wire logic        wide_counter_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             found_o,
  output logic [2:0]       divider_code_o,
  output logic [15:0]      timer_top_o,
  output logic [31:0]      achieved_period_us_o
);

  `include "timer_prescaler_top_search_defines.svh"

  localparam int unsigned NDIV = 5;

  logic [6:0] clock_q;

  logic        v1_q;
  logic [31:0] period1_q;
  logic        wide1_q;
  logic [38:0] prod1_q;

  logic        vp_q      [NDIV];
  logic [31:0] periodp_q [NDIV];
  tps_lane_t   lanes_q   [NDIV][TPS_LANES];
  tps_lane_t   lanes_d   [NDIV][TPS_LANES];
  logic        enp       [NDIV];

  logic        out_valid_q;
  logic        found_q;
  logic [2:0]  code_q;
  logic [15:0] top_q;
  logic [31:0] ach_q;
  logic [31:0] period_out_q;

  logic      en_out, en1;
  tps_pick_t pick;

  assign en_out = !out_valid_q || !out_stall_i;
  always_comb begin
    enp[NDIV-1] = !vp_q[NDIV-1] || en_out;
    for (int j = NDIV - 2; j >= 0; j--) begin
      enp[j] = !vp_q[j] || enp[j+1];
    end
  end
  assign en1        = !v1_q || enp[0];
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= CLOCK_RESET;
    end else if (cfg_we_i) begin
      clock_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      period1_q <= requested_period_us_i;
      wide1_q   <= wide_counter_i;
      prod1_q   <= 39'(requested_period_us_i) * 39'(clock_q);
    end
  end

  always_comb begin
    logic [38:0] t;
    logic [38:0] limit;
    logic [9:0]  mask;
    logic [3:0]  sh;
    logic [3:0]  idx;
    idx   = '0;
    limit = {23'd0, (wide1_q ? WIDE_MAX : NARROW_MAX)};
    for (int k = 0; k < TPS_LANES; k++) begin
      sh   = div_shift(3'(k));
      t    = prod1_q >> sh;
      mask = 10'((11'd1 << sh) - 11'd1);
      lanes_d[0][k].cand  = (t != 39'd0) && (t <= limit);
      lanes_d[0][k].ticks = t[15:0];
      lanes_d[0][k].num   = 11'(prod1_q[9:0] & mask) + 11'(clock_q) - 11'd1;
      lanes_d[0][k].rem   = '0;
      lanes_d[0][k].quo   = '0;
    end
    for (int j = 1; j < NDIV; j++) begin
      for (int k = 0; k < TPS_LANES; k++) begin
        lanes_d[j][k] = lanes_q[j-1][k];
        for (int b = 0; b < 3; b++) begin
          if ((j < NDIV - 1) || (b < 2)) begin
            idx = 4'(13 - 3 * j - b);
            lanes_d[j][k] = div_step(lanes_d[j][k], clock_q, idx);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NDIV; j++) begin
        vp_q[j] <= 1'b0;
      end
    end else begin
      if (enp[0]) begin
        vp_q[0] <= v1_q;
      end
      for (int j = 1; j < NDIV; j++) begin
        if (enp[j]) begin
          vp_q[j] <= vp_q[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enp[0]) begin
      periodp_q[0] <= period1_q;
    end
    for (int j = 1; j < NDIV; j++) begin
      if (enp[j]) begin
        periodp_q[j] <= periodp_q[j-1];
      end
    end
    for (int j = 0; j < NDIV; j++) begin
      if (enp[j]) begin
        lanes_q[j] <= lanes_d[j];
      end
    end
  end

  tps_pick u_pick (
    .lanes_i (lanes_q[NDIV-1]),
    .pick_o  (pick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_out) begin
      out_valid_q <= vp_q[NDIV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      found_q      <= pick.found;
      code_q       <= pick.found ? pick.code : 3'd0;
      top_q        <= pick.found ? pick.ticks - 16'd1 : 16'd0;
      ach_q        <= pick.found ? periodp_q[NDIV-1] - 32'(pick.err) : 32'd0;
      period_out_q <= periodp_q[NDIV-1];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign found_o              = found_q;
  assign divider_code_o       = code_q;
  assign timer_top_o          = top_q;
  assign achieved_period_us_o = ach_q;

  `TPS_ASSERT_IMP(a_empty_result, out_valid_o && !found_o,
                  divider_code_o == 3'd0 && timer_top_o == 16'd0 && achieved_period_us_o == 32'd0,
                  "Empty result carries nonzero fields.")
  `TPS_ASSERT_IMP(a_found_code, out_valid_o && found_o, divider_code_o != 3'd0,
                  "Found result has no divider code.")
  `TPS_ASSERT_IMP(a_ach_bound, out_valid_o && found_o, achieved_period_us_o <= period_out_q,
                  "Achieved period exceeds the request.")
  `TPS_ASSERT(a_stall_cause, !in_stall_o || (out_valid_o && out_stall_i),
              "Input stalled while the output is free.")

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the timer prescaler and top value search block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import tps_pkg::*;

  typedef struct packed {
    logic        found;
    logic [2:0]  code;
    logic [15:0] top;
    logic [31:0] achieved;
  } timing_t;

  typedef struct {
    logic [31:0] period;
    logic        wide;
    logic        known;
    timing_t     want;
  } stim_row_t;

  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] period = '0;
  logic        wide = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [2:0]  divider_code;
  logic [15:0] timer_top;
  logic [31:0] achieved;

  logic [6:0] clock_mhz = CLOCK_RESET;
  timing_t    pending_timings[$];
  int         errors = 0;
  int         idle_cycles = 0;
  bit         hold_req = 1'b0;
  int         burst_left = 0;

  always #4 clk = ~clk;

  timer_prescaler_top_search dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .requested_period_us_i(period),
    .wide_counter_i(wide),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .found_o(found),
    .divider_code_o(divider_code),
    .timer_top_o(timer_top),
    .achieved_period_us_o(achieved)
  );

  function automatic timing_t best_timing(logic [31:0] p, logic w, logic [6:0] mhz);
    longint unsigned dividers[7] = '{1, 8, 32, 64, 128, 256, 1024};
    longint unsigned lim, ticks, ach, err, min_err;
    timing_t r;
    logic have;
    r = '0;
    have = 1'b0;
    min_err = 0;
    lim = w ? 64'hFFFF : 64'hFF;
    for (int k = 0; k < 7; k++) begin
      ticks = (longint'(p) * longint'(mhz)) / dividers[k];
      if (mhz != 0 && ticks >= 1 && ticks <= lim) begin
        ach = (ticks * dividers[k]) / longint'(mhz);
        err = (ach > p) ? ach - p : p - ach;
        if (!have || err < min_err) begin
          have = 1'b1;
          min_err = err;
          r.found = 1'b1;
          r.code = 3'(k + 1);
          r.top = 16'(ticks - 1);
          r.achieved = 32'(ach);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_period();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel < 4) return $urandom;
    return $urandom >> $urandom_range(6, 31);
  endfunction

  // Offers one word and returns once it is accepted; gaps follow the burst pattern.
  task automatic send_word(logic [31:0] p, logic w, logic known, timing_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    period = p;
    wide = w;
    do @(posedge clk); while (in_stall);
    pending_timings.push_back(known ? want : best_timing(p, w, clock_mhz));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic set_clock(logic [6:0] mhz);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_timings.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = mhz;
    @(negedge clk);
    cfg_we = 1'b0;
    clock_mhz = mhz;
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      out_stall = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
      out_stall = 1'b0;
    end else if ($urandom_range(0, 99) < 50) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    timing_t got;
    timing_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{found, divider_code, timer_top, achieved};
      if (pending_timings.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word: %p", got);
      end else begin
        want = pending_timings.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    logic [6:0] clocks[$];
    rows = '{
      '{32'd0, 1'b0, 1'b1, timing_t'(0)},
      '{32'd0, 1'b1, 1'b1, timing_t'(0)},
      '{32'hFFFFFFFF, 1'b0, 1'b1, timing_t'(0)},
      '{32'hFFFFFFFF, 1'b1, 1'b1, timing_t'(0)},
      '{32'd1, 1'b1, 1'b1, '{1'b1, 3'd1, 16'd15, 32'd1}},
      '{32'd1, 1'b0, 1'b1, '{1'b1, 3'd1, 16'd15, 32'd1}},
      '{32'd15, 1'b0, 1'b0, timing_t'(0)},
      '{32'd16, 1'b0, 1'b0, timing_t'(0)},
      '{32'd100, 1'b0, 1'b0, timing_t'(0)},
      '{32'd1000, 1'b0, 1'b0, timing_t'(0)},
      '{32'd4095, 1'b1, 1'b0, timing_t'(0)},
      '{32'd4096, 1'b1, 1'b0, timing_t'(0)},
      '{32'd20000, 1'b1, 1'b0, timing_t'(0)},
      '{32'd16384, 1'b0, 1'b0, timing_t'(0)},
      '{32'd16385, 1'b0, 1'b0, timing_t'(0)},
      '{32'd4194240, 1'b1, 1'b0, timing_t'(0)},
      '{32'd4194304, 1'b1, 1'b0, timing_t'(0)},
      '{32'd4194305, 1'b1, 1'b0, timing_t'(0)},
      '{32'h55555555, 1'b1, 1'b0, timing_t'(0)},
      '{32'hAAAAAAAA, 1'b0, 1'b0, timing_t'(0)},
      '{32'd333, 1'b1, 1'b0, timing_t'(0)}
    };
    clocks = '{CLOCK_RESET, 7'd1, 7'd64, 7'd0, 7'd127, 7'd0, 7'd0, CLOCK_RESET};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) send_word(rows[i].period, rows[i].wide, rows[i].known, rows[i].want);
    foreach (clocks[c]) begin
      if (c == 5 || c == 6) clocks[c] = 7'($urandom_range(2, 126));
      if (c > 0) set_clock(clocks[c]);
      for (int n = 0; n < 220; n++) begin
        if (c == 2 && n == 100) hold_req = 1'b1;
        send_word(rand_period(), 1'($urandom), 1'b0, timing_t'(0));
      end
    end
    in_valid = 1'b0;
    wait (pending_timings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
